// ===== rtl/dbs_pkg.sv =====
package dbs_pkg;

  // Size of the per-pixel background store and its fixed-point format.
  localparam int MAX_PIXELS  = 524288;
  localparam int PIX_W       = $clog2(MAX_PIXELS);
  localparam int FRAC_BITS   = 8;
  localparam int DEPTH_W     = 16;
  localparam int LEVEL_W     = DEPTH_W + FRAC_BITS;
  localparam int WORD_W      = LEVEL_W + 1;

  // Configuration register widths.
  localparam int ALPHA_W     = 9;
  localparam int ALPHA_SHIFT = 8;
  localparam int FRAME_W     = 20;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = FRAME_W;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MIN_DEPTH   = 3'd0,
    REG_MAX_DEPTH   = 3'd1,
    REG_FORE_DELTA  = 3'd2,
    REG_ALPHA       = 3'd3,
    REG_WARMUP      = 3'd4,
    REG_FRAME_PIX   = 3'd5
  } cfg_reg_t;

  // Result class of one pixel.
  typedef enum logic [2:0] {
    CLASS_RANGE  = 3'd0,
    CLASS_PLANE  = 3'd1,
    CLASS_SEED   = 3'd2,
    CLASS_UPDATE = 3'd3,
    CLASS_FORE   = 3'd4
  } pixel_class_t;

endpackage

// ===== rtl/dbs_ram.sv =====
module dbs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Read-first: a read and a write of the same word in one cycle return the old word.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/depth_background_subtractor.sv =====
// Channel   Direction  Handshake               Word
// in        sink       in_valid / in_ready     depth_in_mm, plane_reject
// out       source     out_valid / out_ready   pixel_index, pixel_class, depth_out_mm,
//                                              background_mm, last_of_frame
// cfg       sink       cfg_valid / cfg_ready   cfg_index, cfg_data
//
// One word per cycle is sustained. An accepted word is loaded into the update stage registers
// together with the background memory read; the classify and update logic works on both, and
// its result is loaded into the output register, where it can be taken.
// The memory's single read and single write port set that rate.
// After reset the block clears the valid bits of all MAX_PIXELS (524288) memory words and
// meanwhile holds in_ready low; cfg_ready is always high.
// A stalled output stops the update stage and, through it, the input.
module depth_background_subtractor
  import dbs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,

  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [DEPTH_W-1:0]    depth_in_mm,
  input  logic                  plane_reject,

  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [PIX_W-1:0]      pixel_index,
  output logic [2:0]            pixel_class,
  output logic [DEPTH_W-1:0]    depth_out_mm,
  output logic [DEPTH_W-1:0]    background_mm,
  output logic                  last_of_frame,

  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int CMP_W  = (PIX_W + 1 > FRAME_W) ? PIX_W + 1 : FRAME_W;
  localparam int DIFF_W = LEVEL_W + 1;
  localparam int PROD_W = DIFF_W + ALPHA_W + 1;

  // Configuration registers.
  logic [DEPTH_W-1:0] min_depth;
  logic [DEPTH_W-1:0] max_depth;
  logic [DEPTH_W-1:0] fore_delta;
  logic [ALPHA_W-1:0] alpha;
  logic [DEPTH_W-1:0] warmup;
  logic [FRAME_W-1:0] frame_pix;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_depth  <= DEPTH_W'(100);
      max_depth  <= DEPTH_W'(8000);
      fore_delta <= DEPTH_W'(150);
      alpha      <= ALPHA_W'(13);
      warmup     <= DEPTH_W'(30);
      frame_pix  <= FRAME_W'(307200);
    end else if (cfg_valid) begin
      // Indexes past the register list are dropped.
      case (cfg_reg_t'(cfg_index))
        REG_MIN_DEPTH:  min_depth  <= cfg_data[DEPTH_W-1:0];
        REG_MAX_DEPTH:  max_depth  <= cfg_data[DEPTH_W-1:0];
        REG_FORE_DELTA: fore_delta <= cfg_data[DEPTH_W-1:0];
        REG_ALPHA:      alpha      <= cfg_data[ALPHA_W-1:0];
        REG_WARMUP:     warmup     <= cfg_data[DEPTH_W-1:0];
        REG_FRAME_PIX:  frame_pix  <= cfg_data[FRAME_W-1:0];
        default: ;
      endcase
    end
  end

  // Clearing pass: walk the whole memory once after reset, writing zero words so that
  // every pixel starts with no valid background.
  logic             clr_busy;
  logic [PIX_W-1:0] clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_busy <= 1'b1;
      clr_addr <= '0;
    end else if (clr_busy) begin
      clr_addr <= clr_addr + PIX_W'(1);
      if (clr_addr == PIX_W'(MAX_PIXELS - 1)) begin
        clr_busy <= 1'b0;
      end
    end
  end

  // Pipeline handshake. The update stage moves on when the output register is free.
  logic s1_valid;
  logic s1_adv;
  logic accept;

  assign s1_adv   = !out_valid || out_ready;
  assign in_ready = !clr_busy && (!s1_valid || s1_adv);
  assign accept   = in_valid && in_ready;

  // Raster position and frame counting, done at acceptance.
  logic [PIX_W-1:0]    pix_cnt;
  logic [DEPTH_W-1:0]  frames_seen;
  logic [CMP_W-1:0]    npix;
  logic                is_last;

  always_comb begin
    if (frame_pix == '0) begin
      npix = CMP_W'(1);
    end else if (CMP_W'(frame_pix) > CMP_W'(MAX_PIXELS)) begin
      npix = CMP_W'(MAX_PIXELS);
    end else begin
      npix = CMP_W'(frame_pix);
    end
    is_last = (CMP_W'(pix_cnt) + CMP_W'(1)) >= npix;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pix_cnt     <= '0;
      frames_seen <= '0;
    end else if (accept) begin
      if (is_last) begin
        pix_cnt <= '0;
        if (frames_seen != '1) begin
          frames_seen <= frames_seen + DEPTH_W'(1);
        end
      end else begin
        pix_cnt <= pix_cnt + PIX_W'(1);
      end
    end
  end

  // Update stage registers, loaded with the read.
  logic [PIX_W-1:0]   s1_idx;
  logic [DEPTH_W-1:0] s1_depth;
  logic               s1_reject;
  logic               s1_last;
  logic               s1_fore_ok;
  logic               s1_fwd;
  logic [WORD_W-1:0]  s1_fwd_word;

  // Background memory: {valid, level} per pixel.
  logic              ram_we;
  logic [PIX_W-1:0]  ram_waddr;
  logic [WORD_W-1:0] ram_wdata;
  logic [WORD_W-1:0] rd_word;

  logic              upd_we;
  logic [WORD_W-1:0] upd_word;

  assign ram_we    = clr_busy || upd_we;
  assign ram_waddr = clr_busy ? clr_addr : s1_idx;
  assign ram_wdata = clr_busy ? '0 : upd_word;

  dbs_ram #(
    .WIDTH (WORD_W),
    .DEPTH (MAX_PIXELS)
  ) u_bg_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (accept),
    .rd_addr (pix_cnt),
    .rd_data (rd_word)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  // The memory is read-first, so a word written back in the cycle of the next read
  // is forwarded here. Older writes are already in the memory.
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_idx      <= pix_cnt;
      s1_depth    <= depth_in_mm;
      s1_reject   <= plane_reject;
      s1_last     <= is_last;
      s1_fore_ok  <= frames_seen >= warmup;
      s1_fwd      <= upd_we && (s1_idx == pix_cnt);
      s1_fwd_word <= upd_word;
    end
  end

  // Classify and update.
  logic [WORD_W-1:0]        cur_word;
  logic                     old_valid;
  logic [LEVEL_W-1:0]       old_level;
  logic [LEVEL_W-1:0]       sample;
  logic [LEVEL_W-1:0]       margin;
  logic [DIFF_W-1:0]        gap;
  logic                     fore;
  logic [ALPHA_W-1:0]       alpha_sat;
  logic signed [DIFF_W-1:0] diff;
  logic signed [ALPHA_W:0]  alpha_s;
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] mixed;
  logic [LEVEL_W-1:0]       new_level;
  logic                     in_range;
  pixel_class_t             cls;
  logic [DEPTH_W-1:0]       bg_mm;

  always_comb begin
    cur_word  = s1_fwd ? s1_fwd_word : rd_word;
    old_valid = cur_word[LEVEL_W];
    old_level = cur_word[LEVEL_W-1:0];
    sample    = {s1_depth, {FRAC_BITS{1'b0}}};
    margin    = {fore_delta, {FRAC_BITS{1'b0}}};

    // Foreground needs level - sample >= margin with the difference not negative.
    gap  = {1'b0, old_level} - {1'b0, sample};
    fore = s1_fore_ok && !gap[DIFF_W-1] && (gap[LEVEL_W-1:0] >= margin);

    // level + floor(alpha * (sample - level) / 256) equals the weighted mean, floored.
    alpha_sat = (alpha > ALPHA_W'(256)) ? ALPHA_W'(256) : alpha;
    diff      = $signed({1'b0, sample} - {1'b0, old_level});
    alpha_s   = $signed({1'b0, alpha_sat});
    prod      = diff * alpha_s;
    mixed     = $signed({{(PROD_W-LEVEL_W){1'b0}}, old_level}) + (prod >>> ALPHA_SHIFT);
    new_level = mixed[LEVEL_W-1:0];

    in_range = (s1_depth >= min_depth) && (s1_depth <= max_depth);

    upd_we   = 1'b0;
    upd_word = {1'b1, new_level};
    if (!in_range) begin
      cls   = CLASS_RANGE;
      bg_mm = old_valid ? old_level[LEVEL_W-1 -: DEPTH_W] : '0;
    end else if (s1_reject) begin
      cls   = CLASS_PLANE;
      bg_mm = old_valid ? old_level[LEVEL_W-1 -: DEPTH_W] : '0;
    end else if (!old_valid) begin
      cls      = CLASS_SEED;
      bg_mm    = s1_depth;
      upd_we   = s1_valid && s1_adv;
      upd_word = {1'b1, sample};
    end else if (fore) begin
      cls   = CLASS_FORE;
      bg_mm = old_level[LEVEL_W-1 -: DEPTH_W];
    end else begin
      cls    = CLASS_UPDATE;
      bg_mm  = new_level[LEVEL_W-1 -: DEPTH_W];
      upd_we = s1_valid && s1_adv;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_valid) begin
      pixel_index   <= s1_idx;
      pixel_class   <= cls;
      depth_out_mm  <= s1_depth;
      background_mm <= bg_mm;
      last_of_frame <= s1_last;
    end
  end

endmodule

// ===== dv/testbench.sv =====
module testbench
  import dbs_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  // The run has to outlast the clearing pass of the background store and then every word
  // with its longest gaps, so the cycle budget is kept well above that.
  localparam int CYCLE_LIMIT   = 2_000_000;
  // Cycles allowed after the last expected word so that a stray extra word still shows up.
  localparam int DRAIN_CYCLES  = 16;
  localparam int SEGMENTS      = 12;
  localparam int SEGMENT_WORDS = 62;
  localparam int HOLD_CYCLES   = 400;
  localparam int DIR_ROWS      = 44;
  localparam int MIX_W         = LEVEL_W + ALPHA_W + 1;

  // One result word as the block presents it on its output channel.
  typedef struct packed {
    logic [PIX_W-1:0]   idx;
    pixel_class_t       cls;
    logic [DEPTH_W-1:0] depth;
    logic [DEPTH_W-1:0] bg;
    logic               last;
  } pixel_result_t;

  // One row of the directed table: either a register write or a pixel word. A pixel row
  // may carry a result typed in by hand; otherwise the predictor supplies it.
  typedef struct packed {
    logic                  is_reg;
    cfg_reg_t              reg_sel;
    logic [CFG_DATA_W-1:0] value;
    logic [DEPTH_W-1:0]    depth;
    logic                  reject;
    logic                  typed;
    pixel_result_t         want;
  } stim_row_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [DEPTH_W-1:0]    depth_in_mm = '0;
  logic                  plane_reject = 1'b0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [PIX_W-1:0]      pixel_index;
  logic [2:0]            pixel_class;
  logic [DEPTH_W-1:0]    depth_out_mm;
  logic [DEPTH_W-1:0]    background_mm;
  logic                  last_of_frame;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  cfg_reg_t              cfg_index = REG_MIN_DEPTH;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  initial forever #4 clk = ~clk;

  depth_background_subtractor i_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .depth_in_mm   (depth_in_mm),
    .plane_reject  (plane_reject),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .pixel_index   (pixel_index),
    .pixel_class   (pixel_class),
    .depth_out_mm  (depth_out_mm),
    .background_mm (background_mm),
    .last_of_frame (last_of_frame),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // Predictor state: its own copy of the background store, the frame position and the
  // register file, starting from the reset values of the block.
  bit [LEVEL_W-1:0]   bg_level [MAX_PIXELS];
  bit                 bg_valid [MAX_PIXELS];
  bit [15:0]          frames_seen_m = '0;
  bit [PIX_W-1:0]     pixel_count_m = '0;
  bit [DEPTH_W-1:0]   range_lo_m = 16'd100;
  bit [DEPTH_W-1:0]   range_hi_m = 16'd8000;
  bit [DEPTH_W-1:0]   delta_m = 16'd150;
  bit [ALPHA_W-1:0]   alpha_m = 9'd13;
  bit [15:0]          warmup_m = 16'd30;
  bit [FRAME_W-1:0]   frame_pix_m = 20'd307200;

  // Result words predicted for accepted pixels, oldest first.
  pixel_result_t pending_pixels [$];
  stim_row_t     stim_table [DIR_ROWS];
  int            mismatches = 0;
  int            sender_idle_pct = 0;
  int            recv_idle_pct = 0;
  int            seg_base = 0;
  bit            hold_req = 1'b0;

  // Classifies one pixel the way the block does and advances the predictor state.
  function automatic pixel_result_t classify_pixel(logic [DEPTH_W-1:0] depth, logic reject);
    pixel_result_t      res;
    int                 npix;
    logic [PIX_W-1:0]   idx;
    logic [LEVEL_W-1:0] level;
    logic [LEVEL_W-1:0] sample;
    logic [LEVEL_W-1:0] margin;
    logic [ALPHA_W-1:0] a;
    logic [MIX_W-1:0]   mix;
    npix = int'(frame_pix_m);
    if (npix == 0) npix = 1;
    if (npix > MAX_PIXELS) npix = MAX_PIXELS;
    idx = pixel_count_m;
    sample = LEVEL_W'(depth) << FRAC_BITS;
    margin = LEVEL_W'(delta_m) << FRAC_BITS;
    res.idx = idx;
    res.depth = depth;
    if (depth < range_lo_m || depth > range_hi_m) begin
      res.cls = CLASS_RANGE;
    end else if (reject) begin
      res.cls = CLASS_PLANE;
    end else if (!bg_valid[idx]) begin
      bg_level[idx] = sample;
      bg_valid[idx] = 1'b1;
      res.cls = CLASS_SEED;
    end else begin
      level = bg_level[idx];
      // Foreground needs the warm-up done and the sample nearer by at least the margin,
      // compared at full fixed-point precision.
      if (frames_seen_m >= warmup_m && level >= sample && (level - sample) >= margin) begin
        res.cls = CLASS_FORE;
      end else begin
        a = (alpha_m > 9'd256) ? 9'd256 : alpha_m;
        mix = MIX_W'(9'd256 - a) * MIX_W'(level) + MIX_W'(a) * MIX_W'(sample);
        bg_level[idx] = LEVEL_W'(mix >> ALPHA_SHIFT);
        res.cls = CLASS_UPDATE;
      end
    end
    res.bg = bg_valid[idx] ? DEPTH_W'(bg_level[idx] >> FRAC_BITS) : '0;
    // A counter already at or past the last index ends the frame on this pixel.
    res.last = (int'(pixel_count_m) + 1 >= npix);
    if (res.last) begin
      pixel_count_m = '0;
      if (frames_seen_m != 16'hFFFF) frames_seen_m++;
    end else begin
      pixel_count_m++;
    end
    return res;
  endfunction

  function automatic void apply_reg(cfg_reg_t sel, logic [CFG_DATA_W-1:0] value);
    case (sel)
      REG_MIN_DEPTH:  range_lo_m = value[DEPTH_W-1:0];
      REG_MAX_DEPTH:  range_hi_m = value[DEPTH_W-1:0];
      REG_FORE_DELTA: delta_m = value[DEPTH_W-1:0];
      REG_ALPHA:      alpha_m = value[ALPHA_W-1:0];
      REG_WARMUP:     warmup_m = value[15:0];
      REG_FRAME_PIX:  frame_pix_m = value[FRAME_W-1:0];
      default: ;
    endcase
  endfunction

  function automatic void check_field(string name, logic [31:0] want_v, logic [31:0] got_v);
    if (got_v !== want_v) begin
      $error("%s: expected %0d, got %0d", name, want_v, got_v);
      mismatches++;
    end
  endfunction

  // Builders for the rows of the directed table.
  function automatic stim_row_t word_row(logic [DEPTH_W-1:0] d, logic r);
    stim_row_t row;
    row = '0;
    row.depth = d;
    row.reject = r;
    return row;
  endfunction

  function automatic stim_row_t known_row(logic [DEPTH_W-1:0] d, logic r, logic [PIX_W-1:0] idx,
                                          pixel_class_t cls, logic [DEPTH_W-1:0] bg, logic last);
    stim_row_t row;
    row = word_row(d, r);
    row.typed = 1'b1;
    row.want = '{idx: idx, cls: cls, depth: d, bg: bg, last: last};
    return row;
  endfunction

  function automatic stim_row_t reg_row(cfg_reg_t sel, logic [CFG_DATA_W-1:0] value);
    stim_row_t row;
    row = '0;
    row.is_reg = 1'b1;
    row.reg_sel = sel;
    row.value = value;
    return row;
  endfunction

  // Picks the next random pixel word. Most words land near the background level of the
  // current setting, either close to it or nearer by about the margin, so that updates
  // and foreground both occur; the rest are uniform in the range, range edges and full-width noise.
  function automatic void pick_word(output logic [DEPTH_W-1:0] d, output logic r);
    int lo;
    int hi;
    int v;
    int roll;
    lo = int'(range_lo_m);
    hi = int'(range_hi_m);
    roll = $urandom_range(99);
    if (hi < lo || roll >= 80) begin
      v = $urandom_range(65535);
    end else if (roll < 35) begin
      v = seg_base + int'($urandom_range(200)) - 100;
    end else if (roll < 60) begin
      v = seg_base - int'(delta_m) - int'($urandom_range(200));
    end else if (roll < 72) begin
      v = $urandom_range(hi, lo);
    end else if ($urandom_range(1) == 1) begin
      v = lo - int'($urandom_range(1));
    end else begin
      v = hi + int'($urandom_range(1));
    end
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    d = v[DEPTH_W-1:0];
    r = ($urandom_range(99) < 8);
  endfunction

  // Offers one pixel word, after an optional random gap, and records its prediction when
  // the block accepts it. A typed row replaces the prediction by its hand-written result.
  task automatic send_word(logic [DEPTH_W-1:0] d, logic r, logic typed, pixel_result_t want);
    pixel_result_t predicted;
    cfg_valid <= 1'b0;
    while (int'($urandom_range(99)) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    depth_in_mm <= d;
    plane_reject <= r;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted = classify_pixel(d, r);
    if (typed) predicted = want;
    pending_pixels = {pending_pixels, predicted};
  endtask

  // Writes one register. The valid stays high so that writes can follow back to back;
  // the next pixel word or the next idle wait lowers it.
  task automatic write_reg(cfg_reg_t sel, logic [CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= sel;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    apply_reg(sel, value);
  endtask

  // Waits until every predicted word has come out and the pipeline has run empty.
  task automatic settle_block();
    in_valid <= 1'b0;
    cfg_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Draws a new register setting: mostly a small frame so that pixels come round again,
  // sometimes the full range of a register.
  task automatic randomize_settings();
    logic [DEPTH_W-1:0]    lo;
    logic [DEPTH_W-1:0]    hi;
    logic [CFG_DATA_W-1:0] frame;
    int                    roll;
    lo = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(200));
    hi = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(65535, 3000));
    roll = $urandom_range(9);
    if (roll == 0) frame = '0;
    else if (roll == 1) frame = 20'($urandom_range(1048575, 25));
    else frame = 20'($urandom_range(24, 1));
    write_reg(REG_MIN_DEPTH, CFG_DATA_W'(lo));
    write_reg(REG_MAX_DEPTH, CFG_DATA_W'(hi));
    write_reg(REG_FORE_DELTA, ($urandom_range(3) == 0) ? CFG_DATA_W'($urandom_range(65535))
                                                       : CFG_DATA_W'($urandom_range(400)));
    write_reg(REG_ALPHA, ($urandom_range(4) == 0) ? CFG_DATA_W'($urandom_range(511, 257))
                                                  : CFG_DATA_W'($urandom_range(256)));
    write_reg(REG_WARMUP, ($urandom_range(4) == 0) ? CFG_DATA_W'($urandom_range(65535))
                                                   : CFG_DATA_W'($urandom_range(3)));
    write_reg(REG_FRAME_PIX, frame);
    seg_base = (lo <= hi) ? int'($urandom_range(hi, lo)) : 0;
  endtask

  // Output side: checks every accepted word against the oldest prediction and decides
  // out_ready for the next cycle. A hold request keeps out_ready low for a long stretch
  // so that the pipeline fills and the input stalls.
  initial begin
    pixel_result_t want;
    int            hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (out_valid === 1'b1 && out_ready) begin
        if (pending_pixels.size() == 0) begin
          $error("unexpected word: pixel_index %0d, pixel_class %0d", pixel_index, pixel_class);
          mismatches++;
        end else begin
          want = pending_pixels.pop_front();
          check_field("pixel_index", want.idx, pixel_index);
          check_field("pixel_class", want.cls, pixel_class);
          check_field("depth_out_mm", want.depth, depth_out_mm);
          check_field("background_mm", want.bg, background_mm);
          check_field("last_of_frame", want.last, last_of_frame);
        end
      end
      if (hold_req && hold_left == 0) hold_left = HOLD_CYCLES;
      if (hold_left > 0) begin
        hold_left--;
        if (hold_left == 0) hold_req = 1'b0;
        out_ready <= 1'b0;
      end else begin
        out_ready <= (int'($urandom_range(99)) >= recv_idle_pct);
      end
    end
  end

  // Cycle budget for the whole run; reaching it means the block hung somewhere.
  initial begin
    int cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    logic [DEPTH_W-1:0] d;
    logic               r;
    // The first rows run at the reset setting, where the frame is far longer than the
    // table, so every pixel is fresh and its result can be read off directly.
    stim_table = '{
      known_row(16'd99, 1'b0, 19'd0, CLASS_RANGE, 16'd0, 1'b0),      // just below the minimum
      known_row(16'd100, 1'b0, 19'd1, CLASS_SEED, 16'd100, 1'b0),    // minimum is inclusive
      known_row(16'd8000, 1'b0, 19'd2, CLASS_SEED, 16'd8000, 1'b0),  // maximum is inclusive
      known_row(16'd8001, 1'b0, 19'd3, CLASS_RANGE, 16'd0, 1'b0),
      known_row(16'hFFFF, 1'b1, 19'd4, CLASS_RANGE, 16'd0, 1'b0),    // range test comes first
      known_row(16'd0, 1'b0, 19'd5, CLASS_RANGE, 16'd0, 1'b0),
      known_row(16'd500, 1'b1, 19'd6, CLASS_PLANE, 16'd0, 1'b0),
      // Shrinking the frame below the current position ends the frame on the next pixel.
      reg_row(REG_FRAME_PIX, 20'd4),
      reg_row(REG_WARMUP, 20'd0),
      reg_row(REG_ALPHA, 20'd256),
      reg_row(REG_MIN_DEPTH, 20'd0),
      reg_row(REG_MAX_DEPTH, 20'd65535),
      known_row(16'd1000, 1'b0, 19'd7, CLASS_SEED, 16'd1000, 1'b1),
      known_row(16'hFFFF, 1'b0, 19'd0, CLASS_SEED, 16'hFFFF, 1'b0),
      word_row(16'd0, 1'b0),       // full weight pulls the background down to the sample
      word_row(16'd2000, 1'b0),    // far nearer than the background: foreground
      word_row(16'd5, 1'b0),
      reg_row(REG_ALPHA, 20'd0),
      reg_row(REG_FORE_DELTA, 20'd0),
      word_row(16'hFFFF, 1'b0),    // equal to the background with a zero margin
      word_row(16'd10, 1'b0),      // zero weight leaves the background alone
      word_row(16'd1234, 1'b1),    // rejected pixel still reports its background
      word_row(16'd7, 1'b0),
      // Weight above full scale saturates; the warm-up never ends.
      reg_row(REG_ALPHA, 20'd511),
      reg_row(REG_FORE_DELTA, 20'd65535),
      reg_row(REG_WARMUP, 20'd65535),
      word_row(16'd100, 1'b0),
      word_row(16'd3000, 1'b0),
      word_row(16'd9, 1'b0),
      word_row(16'd6, 1'b0),
      // Minimum above maximum accepts nothing; a zero frame size means one pixel.
      reg_row(REG_MIN_DEPTH, 20'd5000),
      reg_row(REG_MAX_DEPTH, 20'd4000),
      reg_row(REG_FRAME_PIX, 20'd0),
      word_row(16'd4500, 1'b0),
      word_row(16'hFFFF, 1'b1),
      // Frame size beyond the store saturates.
      reg_row(REG_FRAME_PIX, 20'hFFFFF),
      reg_row(REG_MIN_DEPTH, 20'd0),
      reg_row(REG_MAX_DEPTH, 20'd65535),
      reg_row(REG_WARMUP, 20'd0),
      reg_row(REG_ALPHA, 20'd128),
      reg_row(REG_FORE_DELTA, 20'd1),
      word_row(16'd99, 1'b0),      // nearer by exactly the margin
      word_row(16'd200, 1'b0),
      word_row(16'd0, 1'b0)
    };

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Phase one of the idling pattern: a busy sender and a sluggish receiver.
    sender_idle_pct = 11;
    recv_idle_pct = 51;
    foreach (stim_table[i]) begin
      if (stim_table[i].is_reg) begin
        settle_block();
        write_reg(stim_table[i].reg_sel, stim_table[i].value);
      end else begin
        send_word(stim_table[i].depth, stim_table[i].reject, stim_table[i].typed,
                  stim_table[i].want);
      end
    end

    // Random part: each segment gets a fresh register setting. The idling pattern turns
    // round after a third of the segments and is switched off for the last third, where
    // one long receiver hold also backs the pipeline up into the input.
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      settle_block();
      sender_idle_pct = (seg < 4) ? 11 : (seg < 8) ? 51 : 0;
      recv_idle_pct = (seg < 4) ? 51 : (seg < 8) ? 11 : 0;
      randomize_settings();
      if (seg == 9) hold_req = 1'b1;
      for (int n = 0; n < SEGMENT_WORDS; n++) begin
        pick_word(d, r);
        send_word(d, r, 1'b0, '0);
      end
    end

    settle_block();
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/dbs_pkg.sv
rtl/dbs_ram.sv
rtl/depth_background_subtractor.sv
dv/testbench.sv
